// ===== rtl/vas_pkg.sv =====
// Shared types and constants for the voice activity segmenter.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vas_pkg;

	// Configuration port layout
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	// Register indexes, in the order of the register map
	localparam logic [CFG_IDX_BITS-1:0] REG_SPEECH_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SAMPLES    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SILENCE_LEN   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SPEECH_LEN    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SPEECH_LEN    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPLIT_SILENCE_LEN = 3'd5;

	// Fixed field widths
	localparam int WIN_BITS   = 16;
	localparam int LEN_BITS   = 32;
	localparam int TOTAL_BITS = 32;

	// Result queue sizing
	localparam int OUTQ_DEPTH    = 4;
	localparam int OUTQ_PTR_BITS = 2;
	localparam int OUTQ_CNT_BITS = 3;

	// Window size and length limits, all in samples
	typedef struct packed {
		logic [WIN_BITS-1:0] window_samples;
		logic [LEN_BITS-1:0] min_silence_len;
		logic [LEN_BITS-1:0] min_speech_len;
		logic [LEN_BITS-1:0] max_speech_len;
		logic [LEN_BITS-1:0] split_silence_len;
	} vas_len_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/vas_cfg.sv =====
// Configuration register file of the voice activity segmenter.
// Depends on vas_pkg for register indexes and the length settings struct.
`timescale 1ns / 1ps
`default_nettype none

module vas_cfg #(
	parameter int PROB_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [vas_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [vas_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output logic [PROB_BITS-1:0]                      threshold,
	output vas_pkg::vas_len_cfg_t                     lens
);

	localparam logic [31:0] THR_RESET_W = 32'd32768;

	logic [PROB_BITS-1:0]  threshold_q;
	vas_pkg::vas_len_cfg_t lens_q;

	// Writes are always taken; the user must send them only while the block is idle.
	assign cfg_ready = 1'b1;

	// Register writes, reset to the documented defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q              <= THR_RESET_W[PROB_BITS-1:0];
			lens_q.window_samples    <= 16'd512;
			lens_q.min_silence_len   <= 32'd1600;
			lens_q.min_speech_len    <= 32'd4000;
			lens_q.max_speech_len    <= 32'hFFFF_FFFF;
			lens_q.split_silence_len <= 32'd1568;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vas_pkg::REG_SPEECH_THRESHOLD: begin
					threshold_q <= cfg_data[PROB_BITS-1:0];
				end
				vas_pkg::REG_WINDOW_SAMPLES: begin
					lens_q.window_samples <= cfg_data[vas_pkg::WIN_BITS-1:0];
				end
				vas_pkg::REG_MIN_SILENCE_LEN: begin
					lens_q.min_silence_len <= cfg_data[vas_pkg::LEN_BITS-1:0];
				end
				vas_pkg::REG_MIN_SPEECH_LEN: begin
					lens_q.min_speech_len <= cfg_data[vas_pkg::LEN_BITS-1:0];
				end
				vas_pkg::REG_MAX_SPEECH_LEN: begin
					lens_q.max_speech_len <= cfg_data[vas_pkg::LEN_BITS-1:0];
				end
				vas_pkg::REG_SPLIT_SILENCE_LEN: begin
					lens_q.split_silence_len <= cfg_data[vas_pkg::LEN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign threshold = threshold_q;
	assign lens      = lens_q;

endmodule

`default_nettype wire

// ===== rtl/vas_seg.sv =====
// Segment decision logic: input register, segment state and the per-window update.
// Depends on vas_pkg for the length settings struct and field widths.
`timescale 1ns / 1ps
`default_nettype none

module vas_seg #(
	parameter int COUNT_BITS = 32,
	parameter int PROB_BITS  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                take,
	input  wire logic                                kind,
	input  wire logic [PROB_BITS-1:0]                win_prob,
	input  wire logic [vas_pkg::TOTAL_BITS-1:0]      total_samples,
	input  wire logic [PROB_BITS-1:0]                threshold,
	input  wire vas_pkg::vas_len_cfg_t               lens,
	output logic                                     busy,
	output logic                                     res_valid,
	output logic [COUNT_BITS-1:0]                    res_start,
	output logic [COUNT_BITS-1:0]                    res_end
);

	// Width used to compare positions against the 32-bit length settings
	localparam int LW = (COUNT_BITS > vas_pkg::LEN_BITS) ? COUNT_BITS : vas_pkg::LEN_BITS;
	// Hysteresis of 0.15, rounded, as a fraction of full scale
	localparam longint unsigned HYST_INT = (15 * (64'd1 << PROB_BITS) + 50) / 100;
	localparam logic [PROB_BITS:0] HYST = (PROB_BITS + 1)'(HYST_INT);

	// Input register
	logic                           valid_s1;
	logic                           kind_s1;
	logic [PROB_BITS-1:0]           prob_s1;
	logic [vas_pkg::TOTAL_BITS-1:0] total_s1;

	// Segment state
	logic                  speaking_q;
	logic [COUNT_BITS-1:0] pos_q;
	logic [COUNT_BITS-1:0] sil_q;
	logic [COUNT_BITS-1:0] cend_q;
	logic [COUNT_BITS-1:0] cstart_q;
	logic [COUNT_BITS-1:0] ostart_q;

	// Next-state values
	logic                  speaking_d;
	logic [COUNT_BITS-1:0] pos_d;
	logic [COUNT_BITS-1:0] sil_d;
	logic [COUNT_BITS-1:0] cend_d;
	logic [COUNT_BITS-1:0] cstart_d;
	logic [COUNT_BITS-1:0] ostart_d;

	// Window arithmetic
	logic [COUNT_BITS-1:0] pos_adv;
	logic [COUNT_BITS-1:0] seg_len;
	logic [COUNT_BITS-1:0] sil_eff;
	logic [COUNT_BITS-1:0] sil_dur;
	logic [COUNT_BITS-1:0] speech_len;
	logic                  is_speech;
	logic                  is_quiet;
	logic                  over_max;
	logic                  emit;
	logic [COUNT_BITS-1:0] end_c;

	// Capture one item per accepted handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1  <= kind;
			prob_s1  <= win_prob;
			total_s1 <= total_samples;
		end
	end

	// Position after this window; the window itself starts at the old position.
	assign pos_adv    = pos_q + COUNT_BITS'(lens.window_samples);
	assign seg_len    = pos_adv - ostart_q;
	assign sil_eff    = (sil_q == '0) ? pos_adv : sil_q;
	assign sil_dur    = pos_adv - sil_eff;
	assign speech_len = sil_eff - ostart_q;
	assign is_speech  = prob_s1 >= threshold;
	// Below threshold minus hysteresis; never true when that difference is negative
	assign is_quiet   = ({1'b0, prob_s1} + HYST) < {1'b0, threshold};
	assign over_max   = LW'(seg_len) > LW'(lens.max_speech_len);

	// Per-item state update and result decision
	always_comb begin
		speaking_d = speaking_q;
		pos_d      = pos_q;
		sil_d      = sil_q;
		cend_d     = cend_q;
		cstart_d   = cstart_q;
		ostart_d   = ostart_q;
		emit       = 1'b0;
		end_c      = pos_adv;
		if (kind_s1) begin
			// Flush: close an open segment at the stream length, then clear all
			emit       = speaking_q;
			end_c      = COUNT_BITS'(total_s1);
			speaking_d = 1'b0;
			pos_d      = '0;
			sil_d      = '0;
			cend_d     = '0;
			cstart_d   = '0;
			ostart_d   = '0;
		end else begin
			pos_d = pos_adv;
			if (is_speech) begin
				if (sil_q != '0) begin
					sil_d = '0;
					if (cstart_q < cend_q) begin
						cstart_d = pos_q;
					end
				end
				if (!speaking_q) begin
					speaking_d = 1'b1;
					ostart_d   = pos_q;
				end
			end else if (speaking_q && over_max) begin
				// Too long: split at the remembered silence, or cut here
				emit       = 1'b1;
				speaking_d = 1'b0;
				ostart_d   = '0;
				cend_d     = '0;
				cstart_d   = '0;
				sil_d      = '0;
				if (cend_q != '0) begin
					end_c = cend_q;
					if (!(cstart_q < cend_q)) begin
						speaking_d = 1'b1;
						ostart_d   = cstart_q;
					end
				end
			end else if (is_quiet && speaking_q) begin
				sil_d = sil_eff;
				if (LW'(sil_dur) > LW'(lens.split_silence_len)) begin
					cend_d = sil_eff;
				end
				if ((LW'(sil_dur) >= LW'(lens.min_silence_len)) &&
				    (LW'(speech_len) > LW'(lens.min_speech_len))) begin
					emit       = 1'b1;
					end_c      = sil_eff;
					speaking_d = 1'b0;
					ostart_d   = '0;
					cend_d     = '0;
					cstart_d   = '0;
					sil_d      = '0;
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speaking_q <= 1'b0;
			pos_q      <= '0;
			sil_q      <= '0;
			cend_q     <= '0;
			cstart_q   <= '0;
			ostart_q   <= '0;
		end else if (valid_s1) begin
			speaking_q <= speaking_d;
			pos_q      <= pos_d;
			sil_q      <= sil_d;
			cend_q     <= cend_d;
			cstart_q   <= cstart_d;
			ostart_q   <= ostart_d;
		end
	end

	assign busy      = valid_s1;
	assign res_valid = valid_s1 && emit;
	assign res_start = ostart_q;
	assign res_end   = end_c;

	// A flush always leaves the block idle at position zero.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && kind_s1) |=> (!speaking_q && (pos_q == '0) && (sil_q == '0)))
		else $error("state not cleared after flush");

	// Every result closes or splits a segment that was open.
	a_emit_open: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> speaking_q)
		else $error("result without an open segment");

	// With no segment open, no segment start is remembered.
	a_idle_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		!speaking_q |-> (ostart_q == '0))
		else $error("segment start held while idle");

endmodule

`default_nettype wire

// ===== rtl/vas_outq.sv =====
// Result queue: a small register ring that holds finished segments for the receiver.
// Depends on vas_pkg for the queue depth and pointer widths.
`timescale 1ns / 1ps
`default_nettype none

module vas_outq #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	input  wire logic [COUNT_BITS-1:0]               push_start,
	input  wire logic [COUNT_BITS-1:0]               push_end,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [COUNT_BITS-1:0]                    segment_start,
	output logic [COUNT_BITS-1:0]                    segment_end,
	output logic [vas_pkg::OUTQ_CNT_BITS-1:0]        count
);

	logic [COUNT_BITS-1:0]              start_q [vas_pkg::OUTQ_DEPTH];
	logic [COUNT_BITS-1:0]              end_q   [vas_pkg::OUTQ_DEPTH];
	logic [vas_pkg::OUTQ_PTR_BITS-1:0]  wr_ptr_q;
	logic [vas_pkg::OUTQ_PTR_BITS-1:0]  rd_ptr_q;
	logic [vas_pkg::OUTQ_CNT_BITS-1:0]  count_q;
	logic                               pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			start_q[wr_ptr_q] <= push_start;
			end_q[wr_ptr_q]   <= push_end;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign segment_start = start_q[rd_ptr_q];
	assign segment_end   = end_q[rd_ptr_q];
	assign count         = count_q;

	// The input stall must keep the ring from ever being written when full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ((count_q < vas_pkg::OUTQ_CNT_BITS'(vas_pkg::OUTQ_DEPTH)) || pop))
		else $error("result queue overflow");

	// Fill count and pointers agree on an empty ring.
	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("result queue pointers out of step");

	// The fill count never exceeds the ring depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= vas_pkg::OUTQ_CNT_BITS'(vas_pkg::OUTQ_DEPTH))
		else $error("result queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/voice_activity_segmenter.sv =====
// Voice activity segmenter: turns per-window speech probabilities into segments.
// Channels: the input item carries kind, win_prob and total_samples and is
// accepted when in_valid is high and in_stall is low. A kind of zero is one
// window probability; a kind of one flushes the stream, closing an open segment
// at total_samples and clearing all state. Each item gives zero or one result,
// segment_start and segment_end, taken when out_valid is high and out_stall low.
// Configuration uses cfg_valid/cfg_ready with cfg_index and cfg_data; the user
// must see that it is written only while the block is idle, which the block
// does not enforce. cfg_ready is always high. Timing: one item per cycle while
// in_stall is low. An accepted item is registered and updates the segment
// state on the next edge; if it ends a segment, the result enters the queue
// at that same edge, and out_valid is driven from the queue's fill count.
// Results wait in a four-entry queue; in_stall rises only when that queue plus
// the item in flight could overflow, so a stalled receiver holds up the input
// once the pending results and the item in flight reach four. Reset loads the
// default settings, clears the segment state and empties the queue.
// Depends on vas_pkg, vas_cfg, vas_seg and vas_outq.
`timescale 1ns / 1ps
`default_nettype none

module voice_activity_segmenter #(
	parameter int COUNT_BITS = 32,
	parameter int PROB_BITS  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                kind,
	input  wire logic [PROB_BITS-1:0]                win_prob,
	input  wire logic [vas_pkg::TOTAL_BITS-1:0]      total_samples,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [COUNT_BITS-1:0]                    segment_start,
	output logic [COUNT_BITS-1:0]                    segment_end,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [vas_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [vas_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	logic [PROB_BITS-1:0]               threshold;
	vas_pkg::vas_len_cfg_t              lens;
	logic                               busy;
	logic                               res_valid;
	logic [COUNT_BITS-1:0]              res_start;
	logic [COUNT_BITS-1:0]              res_end;
	logic [vas_pkg::OUTQ_CNT_BITS-1:0]  q_count;
	logic [vas_pkg::OUTQ_CNT_BITS-1:0]  q_claim;
	logic                               take;

	// Room is needed for the queued results, the item in flight and this one.
	assign q_claim  = q_count + vas_pkg::OUTQ_CNT_BITS'(busy);
	assign in_stall = q_claim >= vas_pkg::OUTQ_CNT_BITS'(vas_pkg::OUTQ_DEPTH);
	assign take     = in_valid && !in_stall;

	vas_cfg #(
		.PROB_BITS (PROB_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.threshold (threshold),
		.lens      (lens)
	);

	vas_seg #(
		.COUNT_BITS (COUNT_BITS),
		.PROB_BITS  (PROB_BITS)
	) u_seg (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.kind          (kind),
		.win_prob      (win_prob),
		.total_samples (total_samples),
		.threshold     (threshold),
		.lens          (lens),
		.busy          (busy),
		.res_valid     (res_valid),
		.res_start     (res_start),
		.res_end       (res_end)
	);

	vas_outq #(
		.COUNT_BITS (COUNT_BITS)
	) u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (res_valid),
		.push_start    (res_start),
		.push_end      (res_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.segment_start (segment_start),
		.segment_end   (segment_end),
		.count         (q_count)
	);

endmodule

`default_nettype wire
